// File: src/bmnp_pkg.sv
// Shared types and constants for the bump map normal perturbation block.
// Holds the transaction payload structs, request and register codes, and reset values.
// No dependencies.
package bmnp_pkg;

  localparam int unsigned MaxWidthDefault  = 256;
  localparam int unsigned MaxHeightDefault = 256;
  localparam int unsigned CfgDataW         = 16;
  localparam int unsigned CfgIdxW          = 2;

  localparam logic [8:0]  MapDimReset   = 9'd256;
  localparam logic [15:0] DenomEpsReset = 16'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_DENOM_EPS  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_SHADE = 1'b1
  } req_e;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] tangent_u_x;
    logic signed [31:0] tangent_u_y;
    logic signed [31:0] tangent_u_z;
    logic signed [31:0] tangent_v_x;
    logic signed [31:0] tangent_v_y;
    logic signed [31:0] tangent_v_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_normal_x;
    logic signed [15:0] out_normal_y;
    logic signed [15:0] out_normal_z;
    logic               degenerate;
  } out_t;

endpackage

// File: src/bump_map_normal_perturb.sv
// Bump map normal perturbation: accepts one transaction per clock while not stalled. A shade
// transaction gives a result; a load transaction writes one gradient texel if its index is
// in range and gives no result. Results come from pipelined square roots and dividers (one bit
// per stage) behind the single-port gradient memory; a stalled result freezes the pipeline.
// The gradient memory is not cleared: shade only texels that have been loaded.
module bump_map_normal_perturb
  import bmnp_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
  parameter int unsigned MAX_HEIGHT = MaxHeightDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned EXW   = (XW > 9) ? XW : 9;
  localparam int unsigned EYW   = (YW > 9) ? YW : 9;
  localparam int unsigned PAW   = XW + YW;

  typedef struct packed {
    logic [2:0][63:0] m;
    logic [2:0]       neg;
    logic [2:0][15:0] nrm;
  } dsb_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][15:0] nrm;
    logic             dz;
  } qsb_t;

  typedef struct packed {
    logic             zero;
    logic [2:0][27:0] smag;
    logic [2:0]       rneg;
  } lsb_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] rneg;
  } osb_t;

  logic adv;

  // configuration
  logic [8:0]  map_width_q, map_height_q;
  logic [15:0] denom_eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MapDimReset;
      map_height_q <= MapDimReset;
      denom_eps_q  <= DenomEpsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_data_i[8:0];
        REG_MAP_HEIGHT: map_height_q <= cfg_data_i[8:0];
        REG_DENOM_EPS:  denom_eps_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;

  always_comb begin
    if (map_width_q == '0) begin
      eff_w = XW'(1);
    end else if (EXW'(map_width_q) > EXW'(MAX_WIDTH)) begin
      eff_w = XW'(MAX_WIDTH);
    end else begin
      eff_w = XW'(map_width_q);
    end
    if (map_height_q == '0) begin
      eff_h = YW'(1);
    end else if (EYW'(map_height_q) > EYW'(MAX_HEIGHT)) begin
      eff_h = YW'(MAX_HEIGHT);
    end else begin
      eff_h = YW'(map_height_q);
    end
  end

  // stage 1: texel coordinates
  logic [16+XW-1:0] xprod;
  logic [16+YW-1:0] yprod;
  logic             s1_vld_q;
  in_t              s1_pl_q;
  logic [XW-1:0]    s1_x_q;
  logic [YW-1:0]    s1_y_q;

  assign xprod = (16+XW)'(in_data_i.coord_u[15:0]) * (16+XW)'(eff_w);
  assign yprod = (16+YW)'(in_data_i.coord_v[15:0]) * (16+YW)'(eff_h);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pl_q <= in_data_i;
      s1_x_q  <= xprod[16+XW-1:16];
      s1_y_q  <= yprod[16+YW-1:16];
    end
  end

  // stage 2: memory address
  logic [PAW-1:0] addr_lin;
  logic           s1_shade;
  logic           s1_in_range;
  logic           s2_vld_q, s2_shade_q, s2_we_q;
  logic [AW-1:0]  s2_addr_q;
  logic [63:0]    s2_wdata_q;
  in_t            s2_pl_q;

  assign addr_lin    = PAW'(s1_y_q) * PAW'(eff_w) + PAW'(s1_x_q);
  assign s1_shade    = (s1_pl_q.req_type == REQ_SHADE);
  assign s1_in_range = ({1'b0, s1_pl_q.coord_u} < 33'(Depth));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_addr_q  <= s1_shade ? addr_lin[AW-1:0] : s1_pl_q.coord_u[AW-1:0];
      s2_wdata_q <= {s1_pl_q.tangent_u_y, s1_pl_q.tangent_u_x};
      s2_pl_q    <= s1_pl_q;
    end
  end

  // stage 3: gradient memory read or write
  logic [63:0] grad_mem [Depth];
  logic [63:0] g_q;
  logic        s3_vld_q;
  in_t         s3_pl_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s2_we_q) begin
        grad_mem[s2_addr_q] <= s2_wdata_q;
      end
      if (s2_vld_q && s2_shade_q) begin
        g_q <= grad_mem[s2_addr_q];
      end
      s3_pl_q <= s2_pl_q;
    end
  end

  // stage 4: products and squares
  logic [2:0][31:0] tu3, tv3;
  logic [2:0][15:0] nrm3;
  logic             s4_vld_q;
  logic [2:0][63:0] s4_p1_q, s4_p2_q, s4_squ_q, s4_sqv_q;
  logic [2:0][15:0] s4_nrm_q;

  assign tu3  = {s3_pl_q.tangent_u_z, s3_pl_q.tangent_u_y, s3_pl_q.tangent_u_x};
  assign tv3  = {s3_pl_q.tangent_v_z, s3_pl_q.tangent_v_y, s3_pl_q.tangent_v_x};
  assign nrm3 = {s3_pl_q.normal_z, s3_pl_q.normal_y, s3_pl_q.normal_x};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_p1_q[i]  <= $signed(tv3[i]) * $signed(g_q[63:32]);
        s4_p2_q[i]  <= $signed(tu3[i]) * $signed(g_q[31:0]);
        s4_squ_q[i] <= $signed(tu3[i]) * $signed(tu3[i]);
        s4_sqv_q[i] <= $signed(tv3[i]) * $signed(tv3[i]);
      end
      s4_nrm_q <= nrm3;
    end
  end

  // stage 5: magnitudes and sums of squares
  logic             s5_vld_q;
  logic [2:0][63:0] s5_m1_q, s5_m2_q;
  logic [2:0]       s5_s1_q, s5_s2_q;
  logic [63:0]      s5_sumu_q, s5_sumv_q;
  logic [2:0][15:0] s5_nrm_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s5_m1_q[i] <= s4_p1_q[i][63] ? 64'(0) - s4_p1_q[i] : s4_p1_q[i];
        s5_m2_q[i] <= s4_p2_q[i][63] ? 64'(0) - s4_p2_q[i] : s4_p2_q[i];
        s5_s1_q[i] <= s4_p1_q[i][63];
        s5_s2_q[i] <= s4_p2_q[i][63];
      end
      s5_sumu_q <= s4_squ_q[0] + s4_squ_q[1] + s4_squ_q[2];
      s5_sumv_q <= s4_sqv_q[0] + s4_sqv_q[1] + s4_sqv_q[2];
      s5_nrm_q  <= s4_nrm_q;
    end
  end

  // stage 6: signed delta magnitude
  logic             s6_vld_q;
  dsb_t             s6_sb_q;
  logic [1:0][63:0] s6_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (s5_s1_q[i] == s5_s2_q[i]) begin
          s6_sb_q.m[i]   <= s5_m1_q[i] + s5_m2_q[i];
          s6_sb_q.neg[i] <= s5_s1_q[i];
        end else if (s5_m1_q[i] >= s5_m2_q[i]) begin
          s6_sb_q.m[i]   <= s5_m1_q[i] - s5_m2_q[i];
          s6_sb_q.neg[i] <= s5_s1_q[i];
        end else begin
          s6_sb_q.m[i]   <= s5_m2_q[i] - s5_m1_q[i];
          s6_sb_q.neg[i] <= s5_s2_q[i];
        end
      end
      s6_sb_q.nrm <= s5_nrm_q;
      s6_sum_q    <= {s5_sumv_q, s5_sumu_q};
    end
  end

  // tangent lengths
  logic             la_vld;
  logic [1:0][31:0] la_len;
  dsb_t             la_sb;

  bmnp_isqrt #(.N(32), .L(2), .SW($bits(dsb_t))) u_len_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s6_vld_q),
    .v_i    (s6_sum_q),
    .sb_i   (s6_sb_q),
    .vld_o  (la_vld),
    .r_o    (la_len),
    .sb_o   (la_sb)
  );

  logic        s39_vld_q;
  logic [63:0] s39_prod_q;
  dsb_t        s39_sb_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s39_prod_q <= 64'(la_len[0]) * 64'(la_len[1]);
      s39_sb_q   <= la_sb;
    end
  end

  // root of the length product
  logic             rb_vld;
  logic [0:0][31:0] rb_root;
  dsb_t             rb_sb;

  bmnp_isqrt #(.N(32), .L(1), .SW($bits(dsb_t))) u_root_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s39_vld_q),
    .v_i    (s39_prod_q),
    .sb_i   (s39_sb_q),
    .vld_o  (rb_vld),
    .r_o    (rb_root),
    .sb_o   (rb_sb)
  );

  // denominator
  logic             s72_vld_q;
  logic [32:0]      s72_den_q;
  dsb_t             s72_sb_q;
  logic [2:0][34:0] div1_d;
  qsb_t             div1_sbi;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s72_den_q <= 33'(rb_root[0]) + 33'(denom_eps_q);
      s72_sb_q  <= rb_sb;
    end
  end

  assign div1_d       = {3{s72_den_q, 2'b00}};
  assign div1_sbi.neg = s72_sb_q.neg;
  assign div1_sbi.nrm = s72_sb_q.nrm;
  assign div1_sbi.dz  = (s72_den_q == '0);

  logic             d1_vld;
  logic [2:0][61:0] d1_q;
  qsb_t             d1_sb;

  bmnp_div #(.NW(64), .DW(35), .QW(62), .L(3), .SW($bits(qsb_t))) u_delta_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s72_vld_q),
    .n_i    (s72_sb_q.m),
    .d_i    (div1_d),
    .sb_i   (div1_sbi),
    .vld_o  (d1_vld),
    .q_o    (d1_q),
    .sb_o   (d1_sb)
  );

  // perturbed vector r = normal -/+ delta
  logic             s135_vld_q;
  logic [2:0][63:0] s135_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (d1_sb.dz) begin
          s135_r_q[i] <= 64'($signed(d1_sb.nrm[i]));
        end else if (d1_sb.neg[i]) begin
          s135_r_q[i] <= 64'($signed(d1_sb.nrm[i])) + {2'b00, d1_q[i]};
        end else begin
          s135_r_q[i] <= 64'($signed(d1_sb.nrm[i])) - {2'b00, d1_q[i]};
        end
      end
    end
  end

  logic             s136_vld_q;
  logic [2:0][61:0] s136_mag_q;
  logic [2:0]       s136_neg_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s136_mag_q[i] <= s135_r_q[i][63] ? 62'(64'(0) - s135_r_q[i]) : s135_r_q[i][61:0];
        s136_neg_q[i] <= s135_r_q[i][63];
      end
    end
  end

  logic             s137_vld_q;
  logic [61:0]      s137_max_q;
  logic [2:0][61:0] s137_mag_q;
  logic [2:0]       s137_neg_q;
  logic [61:0]      max01;

  assign max01 = (s136_mag_q[0] > s136_mag_q[1]) ? s136_mag_q[0] : s136_mag_q[1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s137_max_q <= (max01 > s136_mag_q[2]) ? max01 : s136_mag_q[2];
      s137_mag_q <= s136_mag_q;
      s137_neg_q <= s136_neg_q;
    end
  end

  // leading one search, per byte then across bytes
  logic             s138_vld_q;
  logic [7:0]       s138_nz_q;
  logic [7:0][2:0]  s138_pos_q;
  logic [2:0][61:0] s138_mag_q;
  logic [2:0]       s138_neg_q;
  logic [63:0]      max_pad;
  logic [7:0]       nz_d;
  logic [7:0][2:0]  pos_d;

  assign max_pad = {2'b00, s137_max_q};

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      nz_d[c]  = |max_pad[8*c +: 8];
      pos_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (max_pad[8*c + b]) begin
          pos_d[c] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s138_nz_q  <= nz_d;
      s138_pos_q <= pos_d;
      s138_mag_q <= s137_mag_q;
      s138_neg_q <= s137_neg_q;
    end
  end

  logic             s139_vld_q;
  logic [5:0]       s139_sh_q;
  logic             s139_zero_q;
  logic [2:0][61:0] s139_mag_q;
  logic [2:0]       s139_neg_q;
  logic [6:0]       bitlen;

  always_comb begin
    bitlen = '0;
    for (int c = 0; c < 8; c++) begin
      if (s138_nz_q[c]) begin
        bitlen = 7'(8 * c) + 7'(s138_pos_q[c]) + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s139_sh_q   <= (bitlen > 7'd28) ? 6'(bitlen - 7'd28) : 6'd0;
      s139_zero_q <= ~|s138_nz_q;
      s139_mag_q  <= s138_mag_q;
      s139_neg_q  <= s138_neg_q;
    end
  end

  // scale below 2^28, then square and sum
  logic s140_vld_q, s141_vld_q, s142_vld_q;
  lsb_t s140_sb_q, s141_sb_q, s142_sb_q;
  logic [2:0][55:0] s141_sq_q;
  logic [57:0]      s142_sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s140_sb_q.smag[i] <= 28'(s139_mag_q[i] >> s139_sh_q);
        s141_sq_q[i]      <= 56'(s140_sb_q.smag[i]) * 56'(s140_sb_q.smag[i]);
      end
      s140_sb_q.zero <= s139_zero_q;
      s140_sb_q.rneg <= s139_neg_q;
      s141_sb_q      <= s140_sb_q;
      s142_sum_q     <= 58'(s141_sq_q[0]) + 58'(s141_sq_q[1]) + 58'(s141_sq_q[2]);
      s142_sb_q      <= s141_sb_q;
    end
  end

  logic             lc_vld;
  logic [0:0][28:0] lc_len;
  lsb_t             lc_sb;

  bmnp_isqrt #(.N(29), .L(1), .SW($bits(lsb_t))) u_norm_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s142_vld_q),
    .v_i    (s142_sum_q),
    .sb_i   (s142_sb_q),
    .vld_o  (lc_vld),
    .r_o    (lc_len),
    .sb_o   (lc_sb)
  );

  logic [2:0][41:0] div2_n;
  logic [2:0][28:0] div2_d;
  osb_t             div2_sbi;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div2_n[i] = {lc_sb.smag[i], 14'b0};
      div2_d[i] = lc_len[0];
    end
    div2_sbi.zero = lc_sb.zero;
    div2_sbi.rneg = lc_sb.rneg;
  end

  logic             d2_vld;
  logic [2:0][14:0] d2_q;
  osb_t             d2_sb;

  bmnp_div #(.NW(42), .DW(29), .QW(15), .L(3), .SW($bits(osb_t))) u_norm_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (lc_vld),
    .n_i    (div2_n),
    .d_i    (div2_d),
    .sb_i   (div2_sbi),
    .vld_o  (d2_vld),
    .q_o    (d2_q),
    .sb_o   (d2_sb)
  );

  // result register
  logic             out_valid_q;
  out_t             out_q;
  logic [2:0][15:0] comp;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (d2_sb.zero) begin
        comp[i] = '0;
      end else if (d2_sb.rneg[i]) begin
        comp[i] = 16'(0) - {1'b0, d2_q[i]};
      end else begin
        comp[i] = {1'b0, d2_q[i]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_normal_x <= comp[0];
      out_q.out_normal_y <= comp[1];
      out_q.out_normal_z <= comp[2];
      out_q.degenerate   <= d2_sb.zero;
    end
  end

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_shade_q  <= 1'b0;
      s2_we_q     <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      s5_vld_q    <= 1'b0;
      s6_vld_q    <= 1'b0;
      s39_vld_q   <= 1'b0;
      s72_vld_q   <= 1'b0;
      s135_vld_q  <= 1'b0;
      s136_vld_q  <= 1'b0;
      s137_vld_q  <= 1'b0;
      s138_vld_q  <= 1'b0;
      s139_vld_q  <= 1'b0;
      s140_vld_q  <= 1'b0;
      s141_vld_q  <= 1'b0;
      s142_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s2_shade_q  <= s1_shade;
      s2_we_q     <= s1_vld_q && !s1_shade && s1_in_range;
      s3_vld_q    <= s2_vld_q && s2_shade_q;
      s4_vld_q    <= s3_vld_q;
      s5_vld_q    <= s4_vld_q;
      s6_vld_q    <= s5_vld_q;
      s39_vld_q   <= la_vld;
      s72_vld_q   <= rb_vld;
      s135_vld_q  <= d1_vld;
      s136_vld_q  <= s135_vld_q;
      s137_vld_q  <= s136_vld_q;
      s138_vld_q  <= s137_vld_q;
      s139_vld_q  <= s138_vld_q;
      s140_vld_q  <= s139_vld_q;
      s141_vld_q  <= s140_vld_q;
      s142_vld_q  <= s141_vld_q;
      out_valid_q <= d2_vld;
    end
  end

  // advance everything unless a held result is stalled
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate) |->
      (out_data_o.out_normal_x == '0 && out_data_o.out_normal_y == '0 &&
       out_data_o.out_normal_z == '0))
    else $error("degenerate result carries a non-zero normal");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.out_normal_x <= 16'sd16384 && out_data_o.out_normal_x >= -16'sd16384 &&
       out_data_o.out_normal_y <= 16'sd16384 && out_data_o.out_normal_y >= -16'sd16384 &&
       out_data_o.out_normal_z <= 16'sd16384 && out_data_o.out_normal_z >= -16'sd16384))
    else $error("normal component outside unit range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_we_q |-> (s2_vld_q && !s2_shade_q))
    else $error("memory write issued by a shade transaction");
`endif

endmodule

// File: src/bmnp_isqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes in step.
// Carries a sideband vector and a valid bit alongside the lanes.
// No package dependencies.
module bmnp_isqrt #(
  parameter int unsigned N  = 32,
  parameter int unsigned L  = 1,
  parameter int unsigned SW = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [L-1:0][2*N-1:0]   v_i,
  input  logic [SW-1:0]           sb_i,
  output logic                    vld_o,
  output logic [L-1:0][N-1:0]     r_o,
  output logic [SW-1:0]           sb_o
);

  localparam int unsigned RW = N + 1;
  localparam int unsigned PW = N + 3;

  logic [N-1:0]                vld_q;
  logic [L-1:0][RW-1:0]        rem_q  [N];
  logic [L-1:0][RW-1:0]        rem_d  [N];
  logic [L-1:0][N-1:0]         root_q [N];
  logic [L-1:0][N-1:0]         root_d [N];
  logic [L-1:0][2*N-1:0]       val_q  [N];
  logic [L-1:0][2*N-1:0]       val_d  [N];
  logic [SW-1:0]               sb_q   [N];

  always_comb begin
    logic [RW-1:0]  rem_in;
    logic [N-1:0]   root_in;
    logic [2*N-1:0] val_in;
    logic [PW-1:0]  pre;
    logic [PW-1:0]  trial;
    for (int s = 0; s < N; s++) begin
      for (int l = 0; l < L; l++) begin
        if (s == 0) begin
          rem_in  = '0;
          root_in = '0;
          val_in  = v_i[l];
        end else begin
          rem_in  = rem_q[s-1][l];
          root_in = root_q[s-1][l];
          val_in  = val_q[s-1][l];
        end
        pre   = {rem_in, val_in[2*N-1 -: 2]};
        trial = {1'b0, root_in, 2'b01};
        if (pre >= trial) begin
          rem_d[s][l]  = RW'(pre - trial);
          root_d[s][l] = (root_in << 1) | N'(1);
        end else begin
          rem_d[s][l]  = RW'(pre);
          root_d[s][l] = root_in << 1;
        end
        val_d[s][l] = val_in << 2;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < N; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        val_q[s]  <= val_d[s];
        if (s == 0) begin
          sb_q[s] <= sb_i;
        end else begin
          sb_q[s] <= sb_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= (vld_q << 1) | N'(vld_i);
    end
  end

  assign vld_o = vld_q[N-1];
  assign r_o   = root_q[N-1];
  assign sb_o  = sb_q[N-1];

endmodule

// File: src/bmnp_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes in step.
// The quotient must fit in QW bits. Carries a sideband vector and a valid bit.
// No package dependencies.
module bmnp_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 35,
  parameter int unsigned QW = 62,
  parameter int unsigned L  = 1,
  parameter int unsigned SW = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [L-1:0][NW-1:0]  n_i,
  input  logic [L-1:0][DW-1:0]  d_i,
  input  logic [SW-1:0]         sb_i,
  output logic                  vld_o,
  output logic [L-1:0][QW-1:0]  q_o,
  output logic [SW-1:0]         sb_o
);

  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW-1:0]              vld_q;
  logic [L-1:0][NW-1:0]       rem_q [QW];
  logic [L-1:0][NW-1:0]       rem_d [QW];
  logic [L-1:0][QW-1:0]       quo_q [QW];
  logic [L-1:0][QW-1:0]       quo_d [QW];
  logic [L-1:0][DW-1:0]       den_q [QW];
  logic [L-1:0][DW-1:0]       den_d [QW];
  logic [SW-1:0]              sb_q  [QW];

  always_comb begin
    logic [NW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [CW-1:0] trial;
    for (int s = 0; s < QW; s++) begin
      for (int l = 0; l < L; l++) begin
        if (s == 0) begin
          rem_in = n_i[l];
          quo_in = '0;
          den_in = d_i[l];
        end else begin
          rem_in = rem_q[s-1][l];
          quo_in = quo_q[s-1][l];
          den_in = den_q[s-1][l];
        end
        trial = CW'(den_in) << (QW - 1 - s);
        if (CW'(rem_in) >= trial) begin
          rem_d[s][l] = NW'(CW'(rem_in) - trial);
          quo_d[s][l] = (quo_in << 1) | QW'(1);
        end else begin
          rem_d[s][l] = rem_in;
          quo_d[s][l] = quo_in << 1;
        end
        den_d[s][l] = den_in;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_d[s];
        if (s == 0) begin
          sb_q[s] <= sb_i;
        end else begin
          sb_q[s] <= sb_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= (vld_q << 1) | QW'(vld_i);
    end
  end

  assign vld_o = vld_q[QW-1];
  assign q_o   = quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the bump map normal perturbation block.
// Holds a scoreboard class that predicts each shade result, plus stimulus and idling tasks.
// Depends on bmnp_pkg and bump_map_normal_perturb.
`timescale 1ns / 100ps

module testbench;
  import bmnp_pkg::*;

  localparam int unsigned StoreDepth = MaxWidthDefault * MaxHeightDefault;
  localparam int unsigned Latency    = 187;
  localparam int unsigned IdleLimit  = 4000;
  localparam int unsigned ItemsPerPhase = 120;

  class normal_scoreboard;
    bit [63:0]    texels [int unsigned];
    bit [8:0]     width_reg, height_reg;
    bit [15:0]    eps_reg;
    out_t         expected_q [$];
    int unsigned  errors, shades, loads, degenerates, checked;

    function new();
      width_reg = MapDimReset;
      height_reg = MapDimReset;
      eps_reg = DenomEpsReset;
    endfunction

    static function int unsigned eff_dim(bit [8:0] r, int unsigned maxv);
      if (r == 0) return 1;
      return (r > maxv) ? maxv : r;
    endfunction

    static function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function bit [63:0] mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Squares wrap at 64 bits, as the hardware sum does.
    static function bit [63:0] vec_len(longint c [3]);
      bit [63:0] s;
      s = 0;
      for (int i = 0; i < 3; i++) s += mag(c[i]) * mag(c[i]);
      return isqrt(s);
    endfunction

    function void note_input(in_t d);
      longint nrm [3], tu [3], tv [3], r [3];
      bit [63:0] m [3], maxm, sum, len, den, g, m1, m2, mm, q, o;
      longint gu, gv, p1, p2;
      int unsigned w, h, x, y;
      bit neg;
      out_t res;
      if (d.req_type == REQ_LOAD) begin
        if (d.coord_u[31:0] < StoreDepth) begin
          texels[d.coord_u[31:0]] = {d.tangent_u_y, d.tangent_u_x};
          loads++;
        end
        return;
      end
      shades++;
      nrm = '{d.normal_x, d.normal_y, d.normal_z};
      tu = '{d.tangent_u_x, d.tangent_u_y, d.tangent_u_z};
      tv = '{d.tangent_v_x, d.tangent_v_y, d.tangent_v_z};
      w = eff_dim(width_reg, MaxWidthDefault);
      h = eff_dim(height_reg, MaxHeightDefault);
      x = (d.coord_u[15:0] * w) >> 16;
      y = (d.coord_v[15:0] * h) >> 16;
      g = texels.exists((y * w + x) % StoreDepth) ? texels[(y * w + x) % StoreDepth] : 0;
      gu = longint'($signed(g[31:0]));
      gv = longint'($signed(g[63:32]));
      den = isqrt(vec_len(tu) * vec_len(tv)) + eps_reg;
      for (int i = 0; i < 3; i++) begin
        p1 = tv[i] * gv;
        p2 = tu[i] * gu;
        m1 = mag(p1);
        m2 = mag(p2);
        if ((p1 < 0) == (p2 < 0)) begin
          mm = m1 + m2; neg = p1 < 0;
        end else if (m1 >= m2) begin
          mm = m1 - m2; neg = p1 < 0;
        end else begin
          mm = m2 - m1; neg = p2 < 0;
        end
        q = (den != 0) ? mm / (den * 4) : 0;
        r[i] = neg ? nrm[i] + longint'(q) : nrm[i] - longint'(q);
      end
      maxm = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag(r[i]);
        if (m[i] > maxm) maxm = m[i];
      end
      res = '0;
      if (maxm == 0) begin
        res.degenerate = 1'b1;
        degenerates++;
      end else begin
        while (maxm >= (64'h1 << 28)) begin
          maxm >>= 1;
          for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = isqrt(sum);
        for (int i = 0; i < 3; i++) begin
          o = (m[i] * 16384) / len;
          if (r[i] < 0) o = -o;
          case (i)
            0: res.out_normal_x = o[15:0];
            1: res.out_normal_y = o[15:0];
            default: res.out_normal_z = o[15:0];
          endcase
        end
      end
      expected_q.push_back(res);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.out_normal_x !== want.out_normal_x)
        report("out_normal_x", got.out_normal_x, want.out_normal_x);
      if (got.out_normal_y !== want.out_normal_y)
        report("out_normal_y", got.out_normal_y, want.out_normal_y);
      if (got.out_normal_z !== want.out_normal_z)
        report("out_normal_z", got.out_normal_z, want.out_normal_z);
      if (got.degenerate !== want.degenerate)
        report("degenerate", got.degenerate, want.degenerate);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_we_i;
  in_t in_data_i;
  out_t out_data_o;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  normal_scoreboard sb = new();
  bit loaded [int unsigned];
  bit calm;
  int unsigned cur_w = MaxWidthDefault, cur_h = MaxHeightDefault;
  int unsigned idle_cycles;

  bump_map_normal_perturb dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MAP_WIDTH;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check(out_data_o);
  end

  // Idle-cycle watchdog: any transaction on either side clears it.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure, same mix of short and long stalls.
  initial begin
    int unsigned left;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left > 0) begin
        out_stall_i <= 1'b1;
        left--;
      end else begin
        out_stall_i <= 1'b0;
        left = pick_gap();
      end
    end
  end

  task automatic send(in_t d);
    int unsigned gap;
    in_data_i <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic load_texel(int unsigned idx, logic [31:0] gu, logic [31:0] gv);
    in_t d;
    d = '0;
    d.req_type = REQ_LOAD;
    d.coord_u = idx;
    d.coord_v = $urandom();
    d.normal_x = $urandom();
    d.tangent_u_x = gu;
    d.tangent_u_y = gv;
    d.tangent_v_z = $urandom();
    if (idx < StoreDepth) loaded[idx] = 1'b1;
    send(d);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 0;
      1, 2: return $urandom();
      default: return $urandom_range(0, 1 << 19) - (1 << 18);
    endcase
  endfunction

  function automatic logic [15:0] rand_norm();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    return $urandom_range(0, 32768) - 16384;
  endfunction

  // Shade only texels already loaded: fill the one addressed first if needed.
  task automatic shade(in_t d);
    int unsigned x, y, addr;
    d.req_type = REQ_SHADE;
    x = (d.coord_u[15:0] * cur_w) >> 16;
    y = (d.coord_v[15:0] * cur_h) >> 16;
    addr = (y * cur_w + x) % StoreDepth;
    if (!loaded.exists(addr)) load_texel(addr, rand_q16(), rand_q16());
    send(d);
  endtask

  task automatic random_shade();
    in_t d;
    d.coord_u = $urandom();
    d.coord_v = $urandom();
    d.normal_x = rand_norm();
    d.normal_y = rand_norm();
    d.normal_z = rand_norm();
    d.tangent_u_x = rand_q16();
    d.tangent_u_y = rand_q16();
    d.tangent_u_z = rand_q16();
    d.tangent_v_x = rand_q16();
    d.tangent_v_y = rand_q16();
    d.tangent_v_z = rand_q16();
    shade(d);
  endtask

  // Write all three registers one after another, enable held throughout.
  task automatic write_regs(logic [15:0] wval, logic [15:0] hval, logic [15:0] eval);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_MAP_WIDTH;
    cfg_data_i <= wval;
    @(posedge clk_i);
    cfg_idx_i <= REG_MAP_HEIGHT;
    cfg_data_i <= hval;
    @(posedge clk_i);
    cfg_idx_i <= REG_DENOM_EPS;
    cfg_data_i <= eval;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.width_reg = wval[8:0];
    sb.height_reg = hval[8:0];
    sb.eps_reg = eval;
    cur_w = normal_scoreboard::eff_dim(sb.width_reg, MaxWidthDefault);
    cur_h = normal_scoreboard::eff_dim(sb.height_reg, MaxHeightDefault);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
  endtask

  task automatic directed_part();
    in_t d;
    load_texel(0, 0, 0);
    load_texel(StoreDepth - 1, 32'h7fff_ffff, 32'h8000_0000);
    load_texel(32'hffff_fff0, $urandom(), $urandom());  // outside the store: dropped
    load_texel(StoreDepth, $urandom(), $urandom());
    // Zero normal and zero gradients: zero-length result.
    d = '0;
    shade(d);
    // Zero tangents: zero denominator when epsilon is zero.
    d.normal_x = 16'sd16384;
    shade(d);
    d.normal_x = -16'sd16384;
    d.normal_y = 16'sd16384;
    d.normal_z = -16'sd16384;
    shade(d);
    // Non-unit normal with large tangents.
    d.normal_x = 16'sd3;
    d.normal_y = 16'sd0;
    d.normal_z = 16'sd0;
    d.tangent_u_x = 32'h7fff_ffff;
    d.tangent_u_y = 32'h8000_0000;
    d.tangent_u_z = 32'h8000_0000;
    d.tangent_v_x = 32'h8000_0000;
    d.tangent_v_y = 32'h7fff_ffff;
    d.tangent_v_z = 32'h0001_0000;
    d.coord_u = 32'hffff_ffff;
    d.coord_v = 32'hffff_ffff;
    shade(d);
    d.coord_u = 32'h8000_0000;
    d.coord_v = 32'h7fff_0000;
    shade(d);
  endtask

  initial begin
    logic [15:0] phase_cfg [7][3];
    phase_cfg = '{'{256, 256, 1}, '{16'hffff, 16'hffff, 16'hffff}, '{0, 0, 0},
                  '{7, 13, 16'h0100}, '{256, 1, 0}, '{1, 256, 16'h8000},
                  '{100, 200, 2}};
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (phase_cfg[p]) begin
      if (p > 0) drain();
      write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      directed_part();
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 9) == 0) load_texel($urandom(), $urandom(), $urandom());
          else load_texel($urandom_range(0, StoreDepth - 1), rand_q16(), rand_q16());
        end else begin
          random_shade();
        end
      end
    end
    calm = 1'b0;
    drain();
    $display("covered %0d shade and %0d load transactions over %0d register settings",
             sb.shades, sb.loads, 7);
    $display("%0d results checked, %0d of them zero-length", sb.checked, sb.degenerates);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bmnp_pkg.sv
src/bmnp_isqrt.sv
src/bmnp_div.sv
src/bump_map_normal_perturb.sv
verif/testbench.sv
